>>> sv/error_diffusion_dither_macros.svh
// assertion macros for the dither rtl
`ifndef ERROR_DIFFUSION_DITHER_MACROS_SVH
`define ERROR_DIFFUSION_DITHER_MACROS_SVH

// same-cycle implication, clocked on clk_i and masked during reset
`define EDD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dither check failed");

// next-cycle implication
`define EDD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dither check failed");

`endif

>>> sv/edd_pkg.sv
// types, constants and helpers for the error diffusion dither
package edd_pkg;

  localparam int NCH = 3;
  localparam int PIX_W = 8;
  localparam int ERR_W = 9;
  localparam int ENTRY_W = NCH * ERR_W;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_WIDTH_W = 11;
  localparam int HEIGHT_W = 16;
  localparam int WIDTH_RESET = 640;
  localparam int HEIGHT_RESET = 480;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef logic signed [ERR_W-1:0] err_t;

  // per-beat control handed from the sequencer to every lane
  typedef struct packed {
    logic accept;
    logic clear;
    logic has_right;
    logic has_left;
    logic has_below;
    logic last_col;
    logic line_zero;
  } lane_ctl_t;

  // divide by 16 rounding toward zero
  function automatic logic signed [11:0] div16_tz(input logic signed [11:0] x);
    logic signed [11:0] b;
    b = (x < 12'sd0) ? x + 12'sd15 : x;
    return b >>> 4;
  endfunction

endpackage

>>> sv/error_diffusion_dither.sv
// floyd-steinberg dither, one bit per channel, three channel lanes
//
//  port group  dir  beat                 payload
//  s_axis      in   one rgb pixel        tdata: red, green, blue
//  m_axis      out  one dithered pixel   tdata: red, green, blue; tlast: frame end
//  cfg         in   one register write   index, data
//
// one pixel per cycle while the output is not stalled; the right-neighbour carry is held in a register
// the line store read for the next column is issued ahead of its pixel and forwarded
// a result shows in the cycle after its pixel beat and sits in an output register
// a stalled output holds the input off only while that register is full
// reset restores 640x480 and starts a clean frame; no clearing pass is needed
module error_diffusion_dither
  import edd_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [NCH*PIX_W-1:0]  s_axis_tdata_i,   // in_red, in_green, in_blue
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [NCH*PIX_W-1:0]  m_axis_tdata_o,   // out_red, out_green, out_blue
  output logic                  m_axis_tlast_o,   // frame_end
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  `include "error_diffusion_dither_macros.svh"

  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int W_RST = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;

  logic [COL_W-1:0]    width_last_q, width_last_d;
  logic [HEIGHT_W-1:0] height_last_q, height_last_d;
  logic [COL_W-1:0]    col_q, col_d;
  logic [HEIGHT_W-1:0] row_q, row_d;

  logic                out_valid_q, out_valid_d;
  logic [NCH-1:0]      out_bits_q, out_bits_d;
  logic                out_last_q, out_last_d;

  logic in_acc, cfg_acc;
  logic last_col, last_row;
  logic [CFG_WIDTH_W-1:0] cfg_w;

  lane_ctl_t          ctl;
  logic [ENTRY_W-1:0] mem_rdata, mem_wdata;
  logic               mem_we;
  logic [NCH-1:0]     lane_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc = cfg_valid_i && cfg_ready_o;
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  assign last_col = (col_q == width_last_q);
  assign last_row = (row_q == height_last_q);

  assign ctl.accept = in_acc;
  assign ctl.clear = cfg_acc;
  assign ctl.has_right = !last_col;
  assign ctl.has_left = (col_q != '0);
  assign ctl.has_below = !last_row;
  assign ctl.last_col = last_col;
  assign ctl.line_zero = (row_q == '0);

  assign cfg_w = cfg_data_i[CFG_WIDTH_W-1:0];

  // register writes clamp once here and restart the frame
  always_comb begin
    width_last_d = width_last_q;
    height_last_d = height_last_q;
    if (cfg_acc) begin
      unique case (cfg_index_i)
        REG_IMAGE_WIDTH: begin
          if (cfg_w == '0) begin
            width_last_d = '0;
          end else if (32'(cfg_w) > MAX_WIDTH) begin
            width_last_d = COL_W'(MAX_WIDTH - 1);
          end else begin
            width_last_d = COL_W'(cfg_w - 11'd1);
          end
        end
        REG_IMAGE_HEIGHT: begin
          height_last_d = (cfg_data_i == '0) ? '0 : cfg_data_i - 16'd1;
        end
        default: begin
          width_last_d = width_last_q;
        end
      endcase
    end
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_acc) begin
      col_d = '0;
      row_d = '0;
    end else if (in_acc) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + 16'd1;
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  // merge stage: collect lane decisions into the output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_bits_d = out_bits_q;
    out_last_d = out_last_q;
    if (in_acc) begin
      out_valid_d = 1'b1;
      out_bits_d = lane_q;
      out_last_d = last_col && last_row;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_last_q <= COL_W'(W_RST - 1);
      height_last_q <= HEIGHT_W'(HEIGHT_RESET - 1);
      col_q <= '0;
      row_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      width_last_q <= width_last_d;
      height_last_q <= height_last_d;
      col_q <= col_d;
      row_q <= row_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_bits_q <= out_bits_d;
    out_last_q <= out_last_d;
  end

  for (genvar c = 0; c < NCH; c++) begin : g_lane
    edd_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl),
      .pix_i     (s_axis_tdata_i[c*PIX_W +: PIX_W]),
      .mem_err_i (mem_rdata[c*ERR_W +: ERR_W]),
      .q_o       (lane_q[c]),
      .left_wr_o (mem_wdata[c*ERR_W +: ERR_W])
    );
    assign m_axis_tdata_o[c*PIX_W +: PIX_W] = {PIX_W{out_bits_q[c]}};
  end

  // the lower-left share lands one column back; the read runs one column ahead
  assign mem_we = in_acc && ctl.has_below && ctl.has_left;

  edd_line_mem #(
    .Depth (MAX_WIDTH),
    .AddrW (COL_W)
  ) u_line_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (col_q - COL_W'(1)),
    .wdata_i (mem_wdata),
    .raddr_i (col_d),
    .rdata_o (mem_rdata)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o = out_last_q;

  `EDD_ASSERT_IMPL(a_col_in_row, 1'b1, col_q <= width_last_q)
  `EDD_ASSERT_IMPL(a_row_in_frame, 1'b1, row_q <= height_last_q)
  `EDD_ASSERT_NEXT(a_frame_end_out, in_acc && last_col && last_row,
                   m_axis_tvalid_o && m_axis_tlast_o)
  `EDD_ASSERT_NEXT(a_frame_restart, in_acc && last_col && last_row && !cfg_acc,
                   (col_q == '0) && (row_q == '0))

endmodule

>>> sv/edd_lane.sv
// one colour channel: threshold, error split and carries
module edd_lane
  import edd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lane_ctl_t        ctl_i,
  input  logic [PIX_W-1:0] pix_i,
  input  err_t             mem_err_i,
  output logic             q_o,
  output err_t             left_wr_o
);

  err_t rc_q, rc_d;
  err_t bp_q, bp_d;
  err_t brp_q, brp_d;
  err_t tail_q, tail_d;

  err_t              line_err;
  logic signed [10:0] v;
  logic              q;
  err_t              e;
  logic signed [11:0] e_w, e3, e5, e7;
  logic signed [11:0] d1, d3, d5, d7;
  err_t              next_below;

  // entry of the last column lives here, row 0 sees no error from above
  assign line_err = ctl_i.line_zero ? '0 : (ctl_i.last_col ? tail_q : mem_err_i);

  assign v = {3'b000, pix_i} + {{2{rc_q[ERR_W-1]}}, rc_q}
           + {{2{line_err[ERR_W-1]}}, line_err};
  assign q = (v >= 11'sd128);
  assign e = v[ERR_W-1:0] - (q ? 9'd255 : 9'd0);

  assign e_w = {{3{e[ERR_W-1]}}, e};
  assign e3 = (e_w <<< 1) + e_w;
  assign e5 = (e_w <<< 2) + e_w;
  assign e7 = (e_w <<< 3) - e_w;
  assign d1 = div16_tz(e_w);
  assign d3 = div16_tz(e3);
  assign d5 = div16_tz(e5);
  assign d7 = div16_tz(e7);

  assign next_below = brp_q + d5[ERR_W-1:0];
  assign left_wr_o = bp_q + d3[ERR_W-1:0];
  assign q_o = q;

  always_comb begin
    rc_d = rc_q;
    bp_d = bp_q;
    brp_d = brp_q;
    tail_d = tail_q;
    if (ctl_i.clear) begin
      rc_d = '0;
      bp_d = '0;
      brp_d = '0;
    end else if (ctl_i.accept) begin
      rc_d = ctl_i.has_right ? d7[ERR_W-1:0] : '0;
      if (ctl_i.has_below) begin
        if (ctl_i.last_col) begin
          tail_d = next_below;
          bp_d = '0;
          brp_d = '0;
        end else begin
          bp_d = next_below;
          brp_d = d1[ERR_W-1:0];
        end
      end else begin
        bp_d = '0;
        brp_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q <= '0;
      bp_q <= '0;
      brp_q <= '0;
    end else begin
      rc_q <= rc_d;
      bp_q <= bp_d;
      brp_q <= brp_d;
    end
  end

  // only read after a write in the same frame
  always_ff @(posedge clk_i) begin
    tail_q <= tail_d;
  end

endmodule

>>> sv/edd_line_mem.sv
// error line store, one write and one registered read with write forwarding
module edd_line_mem
  import edd_pkg::*;
#(
  parameter int Depth = 1024,
  parameter int AddrW = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               we_i,
  input  logic [AddrW-1:0]   waddr_i,
  input  logic [ENTRY_W-1:0] wdata_i,
  input  logic [AddrW-1:0]   raddr_i,
  output logic [ENTRY_W-1:0] rdata_o
);

  logic [ENTRY_W-1:0] mem [Depth];
  logic [ENTRY_W-1:0] rdata_q;
  logic [ENTRY_W-1:0] byp_q;
  logic               hit_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
    byp_q <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= we_i && (waddr_i == raddr_i);
    end
  end

  assign rdata_o = hit_q ? byp_q : rdata_q;

endmodule

>>> dv/tb_error_diffusion_dither.sv
// self-checking testbench for the error diffusion dither: stream stimulus, predictor, checker
module tb_error_diffusion_dither;
  import edd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_MAX = 1024;

  typedef struct {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } rgb_px_t;

  typedef struct {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             frame_end;
  } dithered_px_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_valid = 1'b0;
  logic [NCH*PIX_W-1:0]  s_data = '0;
  logic                  m_ready = 1'b0;
  logic                  cfg_valid = 1'b0;
  cfg_reg_e              cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic                  s_axis_tready_o;
  logic                  m_axis_tvalid_o;
  logic [NCH*PIX_W-1:0]  m_axis_tdata_o;
  logic                  m_axis_tlast_o;
  logic                  cfg_ready_o;

  error_diffusion_dither #(
    .MAX_WIDTH(LINE_MAX)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_data),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [CFG_WIDTH_W-1:0] cfg_width;
  logic [HEIGHT_W-1:0]    cfg_height;
  int                     line_err[LINE_MAX][NCH];
  int                     carry_right[NCH];
  int                     below_cur[NCH];
  int                     below_next[NCH];
  int                     col_pos;
  int                     row_pos;

  dithered_px_t pending_px[$];
  int           fail_cnt = 0;

  // stimulus shaping
  bit tx_gaps = 1'b1;
  int burst_left = 0;
  int pix_mode = 0;
  int flat_level = 128;
  int rx_mode = 0;
  int rx_period = 4;
  int rx_stall_len = 1;
  int rx_hold = 0;
  int rx_cycle = 0;
  int random_sent = 0;

  function automatic void clear_frame();
    for (int i = 0; i < LINE_MAX; i++) begin
      for (int c = 0; c < NCH; c++) line_err[i][c] = 0;
    end
    for (int c = 0; c < NCH; c++) begin
      carry_right[c] = 0;
      below_cur[c] = 0;
      below_next[c] = 0;
    end
    col_pos = 0;
    row_pos = 0;
  endfunction

  function automatic int eff_cols();
    if (cfg_width == 0) return 1;
    if (cfg_width > LINE_MAX) return LINE_MAX;
    return int'(cfg_width);
  endfunction

  function automatic int eff_rows();
    return (cfg_height == 0) ? 1 : int'(cfg_height);
  endfunction

  function automatic dithered_px_t dither_pixel(input rgb_px_t px);
    dithered_px_t res;
    int   w, h, col, row, v, e, q, nb;
    int   pix[NCH];
    int   lvl[NCH];
    logic has_r, has_l, has_b, last_c, last_r;
    w = eff_cols();
    h = eff_rows();
    col = (col_pos >= w) ? w - 1 : col_pos;
    row = (row_pos >= h) ? h - 1 : row_pos;
    last_c = (col == w - 1);
    last_r = (row == h - 1);
    has_r = !last_c;
    has_l = (col > 0);
    has_b = !last_r;
    pix[0] = int'(px.red);
    pix[1] = int'(px.green);
    pix[2] = int'(px.blue);
    for (int c = 0; c < NCH; c++) begin
      v = pix[c] + carry_right[c] + line_err[col][c];
      q = (v < 128) ? 0 : 255;
      e = v - q;
      lvl[c] = q;
      // integer division truncates toward zero, as the block does
      carry_right[c] = has_r ? (e * 7) / 16 : 0;
      if (has_b) begin
        if (has_l) line_err[col-1][c] = below_cur[c] + (e * 3) / 16;
        nb = below_next[c] + (e * 5) / 16;
        if (last_c) begin
          line_err[col][c] = nb;
          below_cur[c] = 0;
          below_next[c] = 0;
        end else begin
          below_cur[c] = nb;
          below_next[c] = e / 16;
        end
      end else begin
        below_cur[c] = 0;
        below_next[c] = 0;
      end
    end
    res.red = lvl[0][PIX_W-1:0];
    res.green = lvl[1][PIX_W-1:0];
    res.blue = lvl[2][PIX_W-1:0];
    res.frame_end = last_c && last_r;
    if (last_c) begin
      if (last_r) begin
        clear_frame();
      end else begin
        col_pos = 0;
        row_pos = row + 1;
      end
    end else begin
      col_pos = col + 1;
      row_pos = row;
    end
    return res;
  endfunction

  task automatic compare_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      fail_cnt++;
      $display("%0t ns %s: expected %0d, got %0d", $time, name, exp_v, got_v);
    end
  endtask

  // output side: check every beat, then decide the next ready
  always @(posedge clk_i) begin
    dithered_px_t exp_px;
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      if (pending_px.size() == 0) begin
        fail_cnt++;
        $display("%0t ns unexpected output beat: expected none, got %h last %b", $time,
                 m_axis_tdata_o, m_axis_tlast_o);
      end else begin
        exp_px = pending_px.pop_front();
        compare_field("red", int'(exp_px.red), int'(m_axis_tdata_o[PIX_W-1:0]));
        compare_field("green", int'(exp_px.green), int'(m_axis_tdata_o[2*PIX_W-1:PIX_W]));
        compare_field("blue", int'(exp_px.blue), int'(m_axis_tdata_o[3*PIX_W-1:2*PIX_W]));
        compare_field("frame_end", int'(exp_px.frame_end), int'(m_axis_tlast_o));
      end
    end
    rx_cycle++;
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      m_ready <= 1'b0;
    end else begin
      case (rx_mode)
        0:       m_ready <= 1'b1;
        1:       m_ready <= ($urandom_range(99) >= 30);
        default: m_ready <= ((rx_cycle % rx_period) >= rx_stall_len);
      endcase
    end
  end

  task automatic send_pixel(input rgb_px_t px);
    if (tx_gaps && burst_left == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    s_valid <= 1'b1;
    s_data <= {px.blue, px.green, px.red};
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (burst_left > 0) burst_left--;
    pending_px.push_back(dither_pixel(px));
  endtask

  task automatic wait_for_pending();
    s_valid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // leaves cfg valid high so that back-to-back writes need no lowering in between
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_IMAGE_WIDTH) cfg_width = val[CFG_WIDTH_W-1:0];
    else cfg_height = val;
    clear_frame();
  endtask

  task automatic set_frame(input logic [CFG_DATA_W-1:0] wdata,
                           input logic [CFG_DATA_W-1:0] hdata, input int which);
    wait_for_pending();
    case (which)
      0: begin
        write_reg(REG_IMAGE_WIDTH, wdata);
        write_reg(REG_IMAGE_HEIGHT, hdata);
      end
      1: begin
        write_reg(REG_IMAGE_HEIGHT, hdata);
        write_reg(REG_IMAGE_WIDTH, wdata);
      end
      2:       write_reg(REG_IMAGE_WIDTH, wdata);
      default: write_reg(REG_IMAGE_HEIGHT, hdata);
    endcase
    cfg_valid <= 1'b0;
    cfg_data <= CFG_DATA_W'($urandom);
  endtask

  function automatic rgb_px_t mk_px(input int r, input int g, input int b);
    rgb_px_t px;
    px.red = r[PIX_W-1:0];
    px.green = g[PIX_W-1:0];
    px.blue = b[PIX_W-1:0];
    return px;
  endfunction

  function automatic int random_level();
    case (pix_mode)
      0: return $urandom_range(255);
      1: return $urandom_range(112, 144);
      2: begin
        case ($urandom_range(3))
          0:       return 0;
          1:       return 255;
          2:       return 127;
          default: return 128;
        endcase
      end
      default: return flat_level ^ $urandom_range(3);
    endcase
  endfunction

  function automatic rgb_px_t random_pixel();
    return mk_px(random_level(), random_level(), random_level());
  endfunction

  task automatic shuffle_idling();
    tx_gaps = ($urandom_range(3) != 0);
    rx_mode <= $urandom_range(2);
    rx_period <= $urandom_range(3, 9);
    rx_stall_len <= $urandom_range(1, 2);
    pix_mode = $urandom_range(3);
    flat_level = $urandom_range(255);
  endtask

  // a few pixels at the reset geometry of 640x480
  task automatic test_reset_geometry();
    send_pixel(mk_px(0, 0, 0));
    send_pixel(mk_px(255, 255, 255));
    send_pixel(mk_px(128, 127, 64));
  endtask

  // 1x1 frames: every pixel closes a frame and no error travels
  task automatic test_single_pixel_frames();
    set_frame(16'd1, 16'd1, 0);
    send_pixel(mk_px(0, 255, 127));
    send_pixel(mk_px(128, 0, 255));
    send_pixel(mk_px(127, 127, 127));
    send_pixel(mk_px(255, 128, 0));
  endtask

  // 3x2 frame: left, right and bottom edges, then an abort mid frame
  task automatic test_frame_edges();
    set_frame(16'd3, 16'd2, 1);
    send_pixel(mk_px(127, 128, 255));
    send_pixel(mk_px(0, 200, 127));
    send_pixel(mk_px(128, 127, 0));
    send_pixel(mk_px(255, 64, 128));
    send_pixel(mk_px(100, 127, 127));
    send_pixel(mk_px(128, 255, 1));
    send_pixel(mk_px(127, 127, 127));
    send_pixel(mk_px(129, 0, 254));
    // zero width and zero height both act as one
    set_frame(16'd0, 16'd0, 0);
    send_pixel(mk_px(200, 100, 50));
    send_pixel(mk_px(127, 128, 129));
    set_frame(16'd2, 16'hFFFF, 0);
    send_pixel(mk_px(127, 127, 127));
    send_pixel(mk_px(127, 127, 127));
    send_pixel(mk_px(255, 0, 128));
  endtask

  // width register all ones clamps to the full line store
  task automatic test_widest_row();
    set_frame(16'hFFFF, 16'd1, 0);
    tx_gaps = 1'b0;
    rx_mode <= 1;
    for (int i = 0; i < LINE_MAX + 5; i++) begin
      pix_mode = (i % 200 < 100) ? 0 : 1;
      send_pixel(random_pixel());
    end
    random_sent += LINE_MAX + 5;
  endtask

  // receiver holds off long enough for the block to fill and stall its input
  task automatic test_output_holdoff();
    set_frame(16'd5, 16'd4, 0);
    tx_gaps = 1'b0;
    pix_mode = 0;
    rx_hold <= 300;
    for (int i = 0; i < 80; i++) send_pixel(random_pixel());
    random_sent += 80;
    wait_for_pending();
  endtask

  // sender drains everything mid frame, then carries on in the same frame
  task automatic test_drain_mid_frame();
    set_frame(16'd6, 16'd5, 0);
    shuffle_idling();
    for (int i = 0; i < 9; i++) send_pixel(random_pixel());
    wait_for_pending();
    for (int i = 0; i < 20; i++) send_pixel(random_pixel());
    random_sent += 29;
  endtask

  task automatic test_random_frames(input int target);
    logic [CFG_DATA_W-1:0] wdata, hdata;
    int                    goal, n, rows_used;
    goal = random_sent + target;
    while (random_sent < goal) begin
      wdata = CFG_DATA_W'($urandom);
      case ($urandom_range(7))
        0:       wdata[CFG_WIDTH_W-1:0] = 11'd1;
        1:       wdata[CFG_WIDTH_W-1:0] = 11'd2;
        2:       wdata[CFG_WIDTH_W-1:0] = '0;
        3:       wdata[CFG_WIDTH_W-1:0] = CFG_WIDTH_W'($urandom_range(3, 8));
        6:       wdata[CFG_WIDTH_W-1:0] = CFG_WIDTH_W'($urandom_range(25, 64));
        default: wdata[CFG_WIDTH_W-1:0] = CFG_WIDTH_W'($urandom_range(2, 24));
      endcase
      case ($urandom_range(6))
        0:       hdata = '0;
        1:       hdata = 16'd1;
        2:       hdata = 16'd2;
        3:       hdata = 16'hFFFF;
        default: hdata = CFG_DATA_W'($urandom_range(1, 6));
      endcase
      // single-register writes keep the other dimension, which must stay small
      if (eff_cols() > 64 || eff_rows() > 6) set_frame(wdata, hdata, $urandom_range(1));
      else set_frame(wdata, hdata, $urandom_range(3));
      shuffle_idling();
      rows_used = (eff_rows() > 4) ? 4 : eff_rows();
      n = eff_cols() * rows_used * $urandom_range(1, 2) + $urandom_range(0, eff_cols());
      if (n > 160) n = 160;
      for (int i = 0; i < n; i++) send_pixel(random_pixel());
      random_sent += n;
    end
  endtask

  initial begin
    cfg_width = CFG_WIDTH_W'(WIDTH_RESET);
    cfg_height = HEIGHT_W'(HEIGHT_RESET);
    clear_frame();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_geometry();
    test_single_pixel_frames();
    test_frame_edges();
    test_random_frames(160);
    test_output_holdoff();
    test_drain_mid_frame();
    test_widest_row();
    test_random_frames(160);

    wait_for_pending();
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("** error_diffusion_dither: PASSED **");
    end else begin
      $display("** error_diffusion_dither: FAILED **");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("%0t ns timeout with %0d pixels outstanding", $time, pending_px.size());
    $display("** error_diffusion_dither: FAILED **");
    $finish;
  end

endmodule
